// File: rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared widths, constants and the record types passed between the modules.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // Width of the number to factor and of each factor.
  localparam int unsigned WIDTH = 32;

  // Upper bound on the results given for one request.
  localparam int unsigned MAX_RESULTS = 31;

  // Counter widths.
  localparam int unsigned CNT_W  = $clog2(MAX_RESULTS);
  localparam int unsigned STEP_W = $clog2(WIDTH);

  // Trial divisors run 2, 3, 5, 7, ...
  localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(2);
  localparam logic [WIDTH-1:0] FIRST_ODD     = WIDTH'(3);
  localparam logic [WIDTH-1:0] ODD_STEP      = WIDTH'(2);

  // Status and results of the serial divider.
  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] rem;
  } div_res_t;

  // One result request.
  typedef struct packed {
    logic [WIDTH-1:0] factor;
    logic             last;
    logic             error;
  } res_t;

endpackage

// File: rtl/tdf_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring binary long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tdf_pkg::WIDTH-1:0] dividend,
  input  logic [tdf_pkg::WIDTH-1:0] divisor,
  output tdf_pkg::div_res_t        res
);

  logic                          busy_r;
  logic                          done_r;
  logic [tdf_pkg::STEP_W-1:0]    step_r;
  logic [tdf_pkg::WIDTH-1:0]     part_r;
  logic [tdf_pkg::WIDTH-1:0]     quo_r;
  logic [tdf_pkg::WIDTH:0]       trial;
  logic [tdf_pkg::WIDTH:0]       diff;

  // Bring down the next dividend bit and try one subtraction.
  assign trial = {part_r, quo_r[tdf_pkg::WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  // Control: a fixed run of WIDTH steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == tdf_pkg::STEP_W'(tdf_pkg::WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and the dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      part_r <= '0;
      quo_r  <= dividend;
    end else if (busy_r) begin
      if (!diff[tdf_pkg::WIDTH]) begin
        part_r <= diff[tdf_pkg::WIDTH-1:0];
      end else begin
        part_r <= trial[tdf_pkg::WIDTH-1:0];
      end
      quo_r <= {quo_r[tdf_pkg::WIDTH-2:0], ~diff[tdf_pkg::WIDTH]};
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = part_r;

endmodule

// File: rtl/tdf_out_reg.sv
// ----------------------------------------------------------------------------
// Result output register
// Holds one result request so the search never drives the port directly.
// ----------------------------------------------------------------------------
module tdf_out_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  input  tdf_pkg::res_t             push_data,
  output logic                      push_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tdf_pkg::WIDTH-1:0] out_factor,
  output logic                      out_last,
  output logic                      out_error
);

  logic          valid_r;
  tdf_pkg::res_t data_r;

  // The slot is free when empty or being drained this cycle.
  assign push_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data_r <= push_data;
    end
  end

  assign out_valid  = valid_r;
  assign out_factor = data_r.factor;
  assign out_last   = data_r.last;
  assign out_error  = data_r.error;

endmodule

// File: rtl/trial_division_factorizer.sv
// Each trial divisor takes a start state, 32 divider steps and a decision on the
// divider's done pulse; each emitted factor adds an emit state that waits for room.
// Worst case is near 32768 odd divisors per request.
// The serial divider, one quotient bit per cycle, sets the cost of each trial divisor.
// One request is worked on at a time; a new one is taken once the last is queued.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
// ----------------------------------------------------------------------------
// Trial division factorizer
// Emits a number's prime factors in nondecreasing order, last one marked; below two, an error.
// ----------------------------------------------------------------------------
module trial_division_factorizer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tdf_pkg::WIDTH-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tdf_pkg::WIDTH-1:0] out_factor,
  output logic                      out_last,
  output logic                      out_error
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [tdf_pkg::WIDTH-1:0]  rem_r, rem_nxt;
  logic [tdf_pkg::WIDTH-1:0]  div_r, div_nxt;
  logic [tdf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  tdf_pkg::res_t              pend_r, pend_nxt;
  tdf_pkg::div_res_t          div_res;
  logic                       push_ready;
  logic                       push_valid;
  logic                       div_start;

  tdf_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (div_r),
    .res      (div_res)
  );

  tdf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (pend_r),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_factor (out_factor),
    .out_last   (out_last),
    .out_error  (out_error)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign div_start  = (state_r == S_START);
  assign push_valid = (state_r == S_EMIT);

  // Search controller. The divider's quotient doubles as the square test:
  // the search ends once the quotient falls below the divisor or the result cap is hit.
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rem_nxt = in_number;
          div_nxt = tdf_pkg::FIRST_DIVISOR;
          cnt_nxt = '0;
          if (in_number < tdf_pkg::FIRST_DIVISOR) begin
            pend_nxt  = '{factor: '0, last: 1'b1, error: 1'b1};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          if ((div_res.quo < div_r) ||
              (cnt_r == tdf_pkg::CNT_W'(tdf_pkg::MAX_RESULTS - 1))) begin
            // The remainder left over is the final factor.
            pend_nxt  = '{factor: rem_r, last: 1'b1, error: 1'b0};
            state_nxt = S_EMIT;
          end else if (div_res.rem == '0) begin
            // Divides: emit it and retry the same divisor on the quotient.
            pend_nxt  = '{factor: div_r, last: 1'b0, error: 1'b0};
            rem_nxt   = div_res.quo;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_EMIT;
          end else begin
            if (div_r == tdf_pkg::FIRST_DIVISOR) begin
              div_nxt = tdf_pkg::FIRST_ODD;
            end else begin
              div_nxt = div_r + tdf_pkg::ODD_STEP;
            end
            state_nxt = S_START;
          end
        end
      end
      S_EMIT: begin
        if (push_ready) begin
          state_nxt = pend_r.last ? S_IDLE : S_START;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    pend_r <= pend_nxt;
  end

  // The divider only reports back while the controller waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // Trial divisors are two or odd.
  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ((div_r == tdf_pkg::FIRST_DIVISOR) || div_r[0]))
    else $error("even trial divisor above two");

  // An error result always closes its request.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error result not marked last");

  // A taken request blocks the input until its results are queued.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in progress");

endmodule
